>>> rtl/ntp_seconds_to_local_calendar_macros.svh
// Assertion macros shared by the calendar converter.
`ifndef NTP_SECONDS_TO_LOCAL_CALENDAR_MACROS_SVH
`define NTP_SECONDS_TO_LOCAL_CALENDAR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NTPCAL_HOLDS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NTPCAL_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/ntpcal_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ntpcal_pkg;

  localparam logic [7:0]  SYNC_TAG      = 8'hE3;
  localparam logic [31:0] UNIX_FROM_NTP = 32'd2208988800;
  localparam logic [16:0] ZONE_RESET    = 17'd19800;
  localparam logic [16:0] SECS_PER_DAY  = 17'd86400;

  localparam logic [25:0] DAY_RECIP    = 26'd50903316;
  localparam logic [17:0] MIN_RECIP    = 18'd139811;
  localparam logic [11:0] HOUR_RECIP   = 12'd2185;
  localparam logic [16:0] WEEK_RECIP   = 17'd74899;
  localparam logic [17:0] LEAP4_RECIP  = 18'd183860;
  localparam logic [18:0] YEAR_RECIP   = 19'd367720;
  localparam logic [10:0] MONTH_RECIP  = 11'd1714;

  localparam logic [19:0] EPOCH_SHIFT  = 20'd719468;
  localparam logic [19:0] ERA4_START   = 20'd584388;
  localparam logic [19:0] ERA5_START   = 20'd730485;
  localparam logic [11:0] YEAR_ERA4    = 12'd1600;
  localparam logic [11:0] YEAR_ERA5    = 12'd2000;
  localparam logic [11:0] CENTURY_BASE = 12'd2000;
  localparam logic [11:0] CENTURY_END  = 12'd2100;

  typedef struct packed {
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] secs;
  } hms_t;

  typedef struct packed {
    logic       year_in_range;
    logic [4:0] day_of_month;
    logic [3:0] month_num;
    logic [6:0] year_in_century;
    logic [2:0] weekday;
  } date_t;

  // Day of the March-based year on which month index mp starts.
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] r;
    case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/ntp_seconds_to_local_calendar.sv
// Converts an NTP seconds count to local calendar date and time. One beat can enter every
// cycle unless out_tready stalls the output; results pass nine register stages (three for
// the day split, six for the date breakdown). A beat whose tag is not 0xE3 comes out with
// frame_ok low and every other field zero. Zone offset register resets to +19800 seconds
// and the user must write it only while no beat is inside; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

`include "ntp_seconds_to_local_calendar_macros.svh"

module ntp_seconds_to_local_calendar
  import ntpcal_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [16:0] cfg_data,      // zone_offset_seconds
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,      // ntp_seconds
  input  wire logic [7:0]  in_tuser,      // frame_tag
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,     // hours, minutes, secs, day_of_month, month_num,
                                          // year_in_century, weekday, zero fill
  output logic [1:0]       out_tuser      // frame_ok, year_in_range
);

  logic        en;
  logic [16:0] zone_r;
  logic [8:1]  vld_r;
  logic [8:1]  ok_r;
  logic        out_tvalid_r;

  assign en        = !out_tvalid_r || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zone_r <= ZONE_RESET;
    end else if (cfg_valid) begin
      zone_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      vld_r        <= {vld_r[7:1], in_tvalid};
      out_tvalid_r <= vld_r[8];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok_r <= {ok_r[7:1], (in_tuser == SYNC_TAG)};
    end
  end

  // Stage 1: local Unix seconds.
  logic [31:0] t1;
  logic [31:0] t1_r;

  assign t1 = in_tdata + {{15{zone_r[16]}}, zone_r} - UNIX_FROM_NTP;

  always_ff @(posedge clk) begin
    if (en) begin
      t1_r <= t1;
    end
  end

  // Stage 2: day count estimate, low by at most one.
  logic [50:0] day_prod;
  logic [15:0] qa2_r;
  logic [31:0] t2_r;

  assign day_prod = 51'(t1_r[31:7]) * 51'(DAY_RECIP);

  always_ff @(posedge clk) begin
    if (en) begin
      qa2_r <= day_prod[50:35];
      t2_r  <= t1_r;
    end
  end

  // Stage 3: correct the day count, seconds of day.
  logic [31:0] day_base;
  logic [31:0] rem3;
  logic        over;
  logic [15:0] days3_r;
  logic [16:0] sod3_r;

  assign day_base = 32'(qa2_r) * 32'(SECS_PER_DAY);
  assign rem3     = t2_r - day_base;
  assign over     = (rem3[17:0] >= 18'(SECS_PER_DAY));

  always_ff @(posedge clk) begin
    if (en) begin
      days3_r <= over ? qa2_r + 16'd1 : qa2_r;
      sod3_r  <= over ? 17'(rem3[17:0] - 18'(SECS_PER_DAY)) : rem3[16:0];
    end
  end

  // Stages 4 to 6: time of day.
  logic [34:0] tm_prod;
  logic [10:0] tm4_r;
  logic [16:0] sod4_r;

  assign tm_prod = 35'(sod3_r) * 35'(MIN_RECIP);

  always_ff @(posedge clk) begin
    if (en) begin
      tm4_r  <= tm_prod[33:23];
      sod4_r <= sod3_r;
    end
  end

  logic [16:0] sec_rem;
  logic [22:0] hr_prod;
  logic [5:0]  secs5_r;
  logic [10:0] tm5_r;
  logic [4:0]  hq5_r;

  assign sec_rem = sod4_r - 17'(tm4_r) * 17'd60;
  assign hr_prod = 23'(tm4_r) * 23'(HOUR_RECIP);

  always_ff @(posedge clk) begin
    if (en) begin
      secs5_r <= sec_rem[5:0];
      tm5_r   <= tm4_r;
      hq5_r   <= hr_prod[21:17];
    end
  end

  logic [10:0] min_rem;
  hms_t        hms6_r;
  hms_t        hms7_r;
  hms_t        hms8_r;

  assign min_rem = tm5_r - 11'(hq5_r) * 11'd60;

  always_ff @(posedge clk) begin
    if (en) begin
      hms6_r.hours   <= hq5_r;
      hms6_r.minutes <= min_rem[5:0];
      hms6_r.secs    <= secs5_r;
      hms7_r         <= hms6_r;
      hms8_r         <= hms7_r;
    end
  end

  // Stages 4 to 8: calendar date.
  date_t date8;

  ntpcal_date u_date (
    .clk  (clk),
    .en   (en),
    .days (days3_r),
    .date (date8)
  );

  // Output register.
  logic  out_ok_r;
  hms_t  out_hms_r;
  date_t out_date_r;

  always_ff @(posedge clk) begin
    if (en) begin
      out_ok_r   <= ok_r[8];
      out_hms_r  <= ok_r[8] ? hms8_r : '0;
      out_date_r <= ok_r[8] ? date8 : '0;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = {out_date_r.year_in_range, out_ok_r};
  assign out_tdata  = {4'd0, out_date_r.weekday, out_date_r.year_in_century,
                       out_date_r.month_num, out_date_r.day_of_month,
                       out_hms_r.secs, out_hms_r.minutes, out_hms_r.hours};

  `NTPCAL_NEXT(a_last_stage_moves, vld_r[8] && en, out_tvalid, "Beat lost at output stage")
  `NTPCAL_HOLDS(a_bad_tag_zero, out_tvalid && !out_tuser[0],
                out_tdata == '0 && !out_tuser[1], "Rejected beat carries data")
  `NTPCAL_HOLDS(a_fields_legal, out_tvalid && out_tuser[0],
                out_hms_r.hours < 5'd24 && out_hms_r.minutes < 6'd60 &&
                out_hms_r.secs < 6'd60 && out_date_r.month_num != 4'd0 &&
                out_date_r.month_num <= 4'd12 && out_date_r.day_of_month != 5'd0 &&
                out_date_r.weekday != 3'd0, "Calendar field out of range")
  `NTPCAL_HOLDS(a_century_clear, out_tvalid && !out_tuser[1],
                out_date_r.year_in_century == 7'd0, "Year set outside the century")

endmodule

`default_nettype wire

>>> rtl/ntpcal_date.sv
`timescale 1ns / 1ps
`default_nettype none

module ntpcal_date
  import ntpcal_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [15:0] days,
  output date_t            date
);

  // Stage 4: shift to the March-based epoch, split off the era.
  logic [19:0] z;
  logic        era5;
  logic [17:0] doe4;
  logic [16:0] wx4;
  logic [33:0] q7_prod;

  assign z       = 20'(days) + EPOCH_SHIFT;
  assign era5    = (z >= ERA5_START);
  assign doe4    = 18'(z - (era5 ? ERA5_START : ERA4_START));
  assign wx4     = 17'(days) + 17'd4;
  assign q7_prod = 34'(wx4) * 34'(WEEK_RECIP);

  logic [17:0] doe4_r;
  logic        era4_r;
  logic [16:0] wx4_r;
  logic [13:0] q74_r;

  always_ff @(posedge clk) begin
    if (en) begin
      doe4_r <= doe4;
      era4_r <= era5;
      wx4_r  <= wx4;
      q74_r  <= q7_prod[32:19];
    end
  end

  // Stage 5: remove leap days of the era, finish the weekday.
  logic [35:0] a_prod;
  logic [6:0]  leap_cnt;
  logic [2:0]  cent_cnt;
  logic        last_day;
  logic [17:0] n5;
  logic [16:0] wrem;

  assign a_prod   = 36'(doe4_r) * 36'(LEAP4_RECIP);
  assign leap_cnt = a_prod[34:28];
  assign cent_cnt = 3'(doe4_r >= 18'd36524) + 3'(doe4_r >= 18'd73048)
                  + 3'(doe4_r >= 18'd109572) + 3'(doe4_r >= 18'd146096);
  assign last_day = (doe4_r >= 18'd146096);
  assign n5       = doe4_r - 18'(leap_cnt) + 18'(cent_cnt) - 18'(last_day);
  assign wrem     = wx4_r - 17'(q74_r) * 17'd7;

  logic [17:0] n5_r;
  logic [17:0] doe5_r;
  logic        era5_r;
  logic [2:0]  wd5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      n5_r   <= n5;
      doe5_r <= doe4_r;
      era5_r <= era4_r;
      wd5_r  <= wrem[2:0] + 3'd1;
    end
  end

  // Stage 6: year of era.
  logic [36:0] y_prod;

  assign y_prod = 37'(n5_r) * 37'(YEAR_RECIP);

  logic [8:0]  yoe6_r;
  logic [17:0] doe6_r;
  logic        era6_r;
  logic [2:0]  wd6_r;

  always_ff @(posedge clk) begin
    if (en) begin
      yoe6_r <= y_prod[35:27];
      doe6_r <= doe5_r;
      era6_r <= era5_r;
      wd6_r  <= wd5_r;
    end
  end

  // Stage 7: day of the March-based year.
  logic [1:0]  cent6;
  logic [17:0] year_base;
  logic [17:0] doy_full;

  assign cent6     = 2'(yoe6_r >= 9'd100) + 2'(yoe6_r >= 9'd200) + 2'(yoe6_r >= 9'd300);
  assign year_base = 18'(yoe6_r) * 18'd365 + 18'(yoe6_r[8:2]) - 18'(cent6);
  assign doy_full  = doe6_r - year_base;

  logic [8:0] doy7_r;
  logic [8:0] yoe7_r;
  logic       era7_r;
  logic [2:0] wd7_r;

  always_ff @(posedge clk) begin
    if (en) begin
      doy7_r <= doy_full[8:0];
      yoe7_r <= yoe6_r;
      era7_r <= era6_r;
      wd7_r  <= wd6_r;
    end
  end

  // Stage 8: month index.
  logic [10:0] mp_num;
  logic [21:0] mp_prod;

  assign mp_num  = 11'(doy7_r) * 11'd5 + 11'd2;
  assign mp_prod = 22'(mp_num) * 22'(MONTH_RECIP);

  logic [3:0] mp8_r;
  logic [8:0] doy8_r;
  logic [8:0] yoe8_r;
  logic       era8_r;
  logic [2:0] wd8_r;

  always_ff @(posedge clk) begin
    if (en) begin
      mp8_r  <= mp_prod[21:18];
      doy8_r <= doy7_r;
      yoe8_r <= yoe7_r;
      era8_r <= era7_r;
      wd8_r  <= wd7_r;
    end
  end

  // Final day, month and year, registered by the caller.
  logic [8:0]  dd;
  logic [3:0]  mon;
  logic [11:0] year;
  logic        in_range;
  logic [11:0] yic;

  assign dd       = doy8_r - month_start(mp8_r) + 9'd1;
  assign mon      = (mp8_r < 4'd10) ? mp8_r + 4'd3 : mp8_r - 4'd9;
  assign year     = 12'(yoe8_r) + (era8_r ? YEAR_ERA5 : YEAR_ERA4) + 12'(mon <= 4'd2);
  assign in_range = (year >= CENTURY_BASE) && (year < CENTURY_END);
  assign yic      = year - CENTURY_BASE;

  always_comb begin
    date.year_in_range   = in_range;
    date.day_of_month    = dd[4:0];
    date.month_num       = mon;
    date.year_in_century = in_range ? yic[6:0] : 7'd0;
    date.weekday         = wd8_r;
  end

endmodule

`default_nettype wire
